// File: rtl/core/ipfse_pkg.sv
// Shared types, constants and the CRC-8 step function for the IR packet framer.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ipfse_pkg;

  // Symbol geometry: digits per framed byte and bits per digit.
  localparam int BITS_PER_SYMBOL = 4;
  localparam int DIGITS_PER_BYTE = 2;

  // Most symbols that one input beat may produce; later ones are dropped.
  localparam int MAX_RESULTS = 21;

  localparam int SYM_W = 5;
  localparam int IDX_W = $clog2(DIGITS_PER_BYTE + 1);
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // Framing bytes.
  localparam logic [7:0] SOF_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE = 8'h7D;
  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam logic [SYM_W-1:0] START_SYMBOL = '0;
  localparam logic [SYM_W-1:0] PREV_RESET   = '1;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_e;

  // Which framed byte is going out.
  typedef enum logic [1:0] {
    KIND_SOF,
    KIND_LEN,
    KIND_PAY,
    KIND_CRC
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;
    logic  emit;
    logic  emit_start;
    logic  keep;
    logic  last;
    logic  pay_update;
    logic  esc_part;
    kind_e kind;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_nz;
    logic rem_zero;
    logic len_zero;
    logic needs_esc;
    logic out_stall;
  } dp_status_t;

  // One byte through the SMBus PEC CRC-8, most significant bit first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ipfse_ctrl.sv
// Controller for the IR packet framer: sequences the framed bytes of a beat,
// the escape halves and the symbols of each byte. Depends on ipfse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipfse_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_accept_i,
  input  wire logic                in_first_i,
  input  wire ipfse_pkg::dp_status_t status_i,
  output ipfse_pkg::ctrl_cmd_t     cmd_o,
  output logic                     in_ready_o
);

  import ipfse_pkg::*;

  state_e           state_q, state_d;
  kind_e            kind_q, kind_d;
  logic             esc_q, esc_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic  part_done;
  logic  byte_done;
  logic  final_sym;
  kind_e kind_next;

  // State and sequencing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_SOF;
      esc_q   <= 1'b0;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      esc_q   <= esc_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  // The byte that follows the current one in the frame.
  always_comb begin
    unique case (kind_q)
      KIND_SOF: kind_next = KIND_LEN;
      KIND_LEN: kind_next = status_i.len_zero ? KIND_CRC : KIND_PAY;
      KIND_PAY: kind_next = KIND_CRC;
      KIND_CRC: kind_next = KIND_CRC;
      default:  kind_next = KIND_CRC;
    endcase
  end

  assign part_done = (idx_q == IDX_W'(DIGITS_PER_BYTE));
  assign byte_done = part_done && (!status_i.needs_esc || esc_q);
  assign final_sym = byte_done &&
                     ((kind_q == KIND_CRC) || ((kind_q == KIND_PAY) && !status_i.rem_zero));

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    esc_d      = esc_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;

    cmd_o            = '0;
    cmd_o.kind       = kind_q;
    cmd_o.esc_part   = esc_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_accept_i) begin
          cmd_o.capture = 1'b1;
          cnt_d         = '0;
          esc_d         = 1'b0;
          idx_d         = '0;
          if (in_first_i) begin
            kind_d  = KIND_SOF;
            state_d = ST_SEND;
          end else if (status_i.rem_nz) begin
            kind_d  = KIND_PAY;
            state_d = ST_SEND;
          end
        end
      end

      ST_SEND: begin
        if (!status_i.out_stall) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_start = (idx_q == '0);
          cmd_o.pay_update = (kind_q == KIND_PAY) && !esc_q && (idx_q == '0);
          cmd_o.keep       = (cnt_q != CNT_W'(MAX_RESULTS));
          cmd_o.last       = final_sym || (cnt_q == CNT_W'(MAX_RESULTS - 1));
          if (cnt_q != CNT_W'(MAX_RESULTS)) begin
            cnt_d = cnt_q + CNT_W'(1);
          end

          // Advance through the symbols, the escape halves and the bytes.
          if (part_done) begin
            idx_d = '0;
            if (byte_done) begin
              esc_d = 1'b0;
              if (final_sym) begin
                state_d = ST_IDLE;
              end else begin
                kind_d = kind_next;
              end
            end else begin
              esc_d = 1'b1;
            end
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/ipfse_datapath.sv
// Datapath for the IR packet framer: input capture, CRC and length counters,
// byte stuffing, digit-to-symbol mapping and the output register. Uses ipfse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipfse_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  ipfse_pkg::ctrl_cmd_t      cmd_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 first_i,
  input  wire logic [7:0]           packet_length_i,
  input  wire logic                 out_ready_i,
  output ipfse_pkg::dp_status_t     status_o,
  output logic                      out_valid_o,
  output logic [ipfse_pkg::SYM_W-1:0] out_symbol_o,
  output logic                      out_last_o
);

  import ipfse_pkg::*;

  logic [7:0]       data_q;
  logic [7:0]       len_q;
  logic [7:0]       crc_q, crc_d;
  logic [7:0]       rem_q, rem_d;
  logic [SYM_W-1:0] prev_q;
  logic [7:0]       shift_q;
  logic             out_valid_q;
  logic [SYM_W-1:0] out_sym_q;
  logic             out_last_q;

  logic [7:0]       src_byte;
  logic [7:0]       raw_byte;
  logic             needs_esc;
  logic [SYM_W-1:0] sym_base;
  logic [SYM_W-1:0] sym_digit;
  logic [SYM_W-1:0] sym_out;

  // Byte of the frame selected by the controller, before stuffing.
  always_comb begin
    unique case (cmd_i.kind)
      KIND_SOF: src_byte = SOF_BYTE;
      KIND_LEN: src_byte = len_q;
      KIND_PAY: src_byte = data_q;
      KIND_CRC: src_byte = crc_q;
      default:  src_byte = SOF_BYTE;
    endcase
  end

  // Escape handling: the opening flag is never stuffed.
  assign needs_esc = (cmd_i.kind != KIND_SOF) &&
                     ((src_byte == SOF_BYTE) || (src_byte == ESC_BYTE));

  always_comb begin
    if (cmd_i.esc_part) begin
      raw_byte = src_byte ^ ESC_XOR;
    end else if (needs_esc) begin
      raw_byte = ESC_BYTE;
    end else begin
      raw_byte = src_byte;
    end
  end

  // Digit symbol: digit plus one, bumped past the previous symbol.
  assign sym_base  = SYM_W'(shift_q[BITS_PER_SYMBOL-1:0]) + SYM_W'(1);
  assign sym_digit = (sym_base >= prev_q) ? (sym_base + SYM_W'(1)) : sym_base;
  assign sym_out   = cmd_i.emit_start ? START_SYMBOL : sym_digit;

  // Running CRC and payload count of the open frame.
  always_comb begin
    crc_d = crc_q;
    rem_d = rem_q;
    if (cmd_i.capture && first_i) begin
      crc_d = crc8_byte(8'h00, packet_length_i);
      rem_d = packet_length_i;
    end else if (cmd_i.emit && cmd_i.pay_update) begin
      crc_d = crc8_byte(crc_q, data_q);
      rem_d = rem_q - 8'd1;
    end
  end

  // Frame state and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= '0;
      rem_q       <= '0;
      prev_q      <= PREV_RESET;
      out_valid_q <= 1'b0;
    end else begin
      crc_q <= crc_d;
      rem_q <= rem_d;
      if (cmd_i.emit) begin
        prev_q <= sym_out;
      end
      if (cmd_i.emit && cmd_i.keep) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Captured beat, digit shifter and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      data_q <= data_byte_i;
      len_q  <= packet_length_i;
    end
    if (cmd_i.emit) begin
      if (cmd_i.emit_start) begin
        shift_q <= raw_byte;
      end else begin
        shift_q <= shift_q >> BITS_PER_SYMBOL;
      end
    end
    if (cmd_i.emit && cmd_i.keep) begin
      out_sym_q  <= sym_out;
      out_last_q <= cmd_i.last;
    end
  end

  // Status back to the controller.
  always_comb begin
    status_o.rem_nz    = (rem_q != 8'd0);
    status_o.rem_zero  = (rem_q == 8'd0);
    status_o.len_zero  = (len_q == 8'd0);
    status_o.needs_esc = needs_esc;
    status_o.out_stall = out_valid_q && !out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

// File: rtl/core/ir_packet_framer_symbol_encoder_unit.sv
// IR packet framer: one beat in, up to 21 symbol beats out, one symbol per cycle
// while the output is not stalled. The beat is captured in the idle state, and its
// symbols go from the send state into the output register. Each framed byte it sends
// is a start symbol and two digit symbols; a beat sends at most seven framed bytes.
// The controller works on one beat at a time; output stalls pause the emitter.
// Reset clears the CRC and byte count and sets the previous symbol to 31.
`timescale 1ns / 1ps
`default_nettype none

module ir_packet_framer_symbol_encoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // [7:0] data_byte, [15:8] packet_length
  input  wire logic [0:0]  s_axis_tuser_i,  // [0] first_of_packet
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,  // [4:0] symbol, [7:5] zero
  output logic             m_axis_tlast_o   // run_last
);

  import ipfse_pkg::*;

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic             in_accept;
  logic [SYM_W-1:0] out_symbol;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  // Byte and symbol sequencer.
  ipfse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_first_i  (s_axis_tuser_i[0]),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (s_axis_tready_o)
  );

  // CRC, stuffing, symbol mapping and output register.
  ipfse_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .data_byte_i     (s_axis_tdata_i[7:0]),
    .first_i         (s_axis_tuser_i[0]),
    .packet_length_i (s_axis_tdata_i[15:8]),
    .out_ready_i     (m_axis_tready_i),
    .status_o        (status),
    .out_valid_o     (m_axis_tvalid_o),
    .out_symbol_o    (out_symbol),
    .out_last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {(8 - SYM_W)'(0), out_symbol};

`ifndef SYNTHESIS
  // Symbols stay within the 18-tone alphabet.
  a_symbol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[4:0] <= 5'd17))
    else $error("symbol out of range");

  // A start-of-packet beat always opens a frame, so the block is busy next.
  a_sof_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i[0]) |=> !s_axis_tready_o)
    else $error("start of packet produced no frame");

  // A byte start symbol is never the final symbol of a beat.
  a_start_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[4:0] == 5'd0)) |-> !m_axis_tlast_o)
    else $error("run ended on a byte start symbol");
`endif

endmodule

`default_nettype wire

// File: tb/sv/ir_packet_framer_symbol_encoder_unit_tb.sv
// Self-checking bench for the IR packet framer: drives framed packet beats, predicts
// the symbol stream with a local framing and CRC model, and checks every output beat.
// Depends on ipfse_pkg and ir_packet_framer_symbol_encoder_unit.
`timescale 1ns / 1ps

module ir_packet_framer_symbol_encoder_unit_tb;
  import ipfse_pkg::*;

  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic [7:0] len;
  } in_item_t;

  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } sym_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;  // [7:0] data_byte, [15:8] packet_length
  logic [0:0]  s_axis_tuser_i = '0;  // [0] first_of_packet
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;       // [4:0] symbol, [7:5] zero
  logic        m_axis_tlast_o;       // run_last

  ir_packet_framer_symbol_encoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  in_item_t pending_q[$];
  sym_t     symbol_q[$];
  int       err_cnt = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  logic     in_took = 1'b0;
  logic     hold_ask = 1'b0;
  logic     hold_done = 1'b0;
  int       hold_left = 0;
  logic     gen_open = 1'b0;

  // Framer state as the block should hold it.
  logic [7:0]       pec_crc = '0;
  logic [7:0]       bytes_left = '0;
  logic [SYM_W-1:0] prev_sym_exp = PREV_RESET;
  int               beat_syms;

  // One byte through the SMBus PEC CRC-8, most significant bit first.
  function automatic logic [7:0] pec_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = c[7] ? {c[6:0], 1'b0} ^ CRC_POLY : {c[6:0], 1'b0};
    return c;
  endfunction

  task automatic emit_symbol(input logic [SYM_W-1:0] s);
    prev_sym_exp = s;
    if (beat_syms < MAX_RESULTS) symbol_q.push_back('{s, 1'b0});
    beat_syms++;
  endtask

  // Start symbol, then the digits lowest first, each bumped past the previous symbol.
  task automatic emit_byte(input logic [7:0] b);
    int v;
    int d;
    v = int'(b);
    emit_symbol(START_SYMBOL);
    for (int i = 0; i < DIGITS_PER_BYTE; i++) begin
      d = (v & ((1 << BITS_PER_SYMBOL) - 1)) + 1;
      v = v >> BITS_PER_SYMBOL;
      if (d >= int'(prev_sym_exp)) d++;
      emit_symbol(SYM_W'(d));
    end
  endtask

  task automatic emit_escaped(input logic [7:0] b);
    if (b == SOF_BYTE || b == ESC_BYTE) begin
      emit_byte(ESC_BYTE);
      emit_byte(b ^ ESC_XOR);
    end else begin
      emit_byte(b);
    end
  endtask

  task automatic add_payload(input logic [7:0] b);
    pec_crc = pec_step(pec_crc, b);
    emit_escaped(b);
    bytes_left = bytes_left - 8'd1;
    if (bytes_left == 0) emit_escaped(pec_crc);
  endtask

  // Expected symbols for one accepted input beat.
  task automatic frame_item(input logic [7:0] data, input logic first, input logic [7:0] len);
    sym_t tail;
    beat_syms = 0;
    if (first) begin
      pec_crc = '0;
      bytes_left = len;
      emit_byte(SOF_BYTE);
      pec_crc = pec_step(pec_crc, len);
      emit_escaped(len);
      if (len == 0) emit_escaped(pec_crc);
      else add_payload(data);
    end else if (bytes_left != 0) begin
      add_payload(data);
    end
    if (beat_syms > 0) begin
      tail = symbol_q.pop_back();
      tail.last = 1'b1;
      symbol_q.push_back(tail);
    end
  endtask

  // Input acceptance feeds the prediction; output beats are checked in order.
  always @(posedge clk_i) begin
    sym_t want;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      frame_item(s_axis_tdata_i[7:0], s_axis_tuser_i[0], s_axis_tdata_i[15:8]);
      in_took = 1'b1;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (symbol_q.size() == 0) begin
        $error("unexpected symbol beat: symbol %0d, run_last %0b",
               m_axis_tdata_o[4:0], m_axis_tlast_o);
        err_cnt++;
      end else begin
        want = symbol_q.pop_front();
        if (m_axis_tdata_o[4:0] !== want.symbol) begin
          $error("symbol: expected %0d, actual %0d", want.symbol, m_axis_tdata_o[4:0]);
          err_cnt++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("run_last: expected %0b, actual %0b", want.last, m_axis_tlast_o);
          err_cnt++;
        end
        if (m_axis_tdata_o[7:5] !== 3'b000) begin
          $error("tdata pad: expected 0, actual %0d", m_axis_tdata_o[7:5]);
          err_cnt++;
        end
      end
    end
  end

  // Sender: offers the next pending beat once the current one is taken.
  always @(negedge clk_i) begin
    in_item_t nxt;
    if (!s_axis_tvalid_i || in_took) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = pending_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {nxt.len, nxt.data};
        s_axis_tuser_i  <= nxt.first;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
    in_took = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  always @(negedge clk_i) begin
    if (hold_ask && !hold_done) begin
      hold_left = RX_HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic queue_beat(input logic [7:0] data, input logic first, input logic [7:0] len);
    pending_q.push_back('{data, first, len});
  endtask

  // Payload byte with a bias toward the flag and escape values.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) return SOF_BYTE;
    if (r < 20) return ESC_BYTE;
    return 8'($urandom_range(255));
  endfunction

  // Mostly whole packets with random content; some cut short, some stray beats.
  task automatic make_random_items(input int n);
    int done_cnt;
    int pick;
    int len;
    int k;
    done_cnt = 0;
    while (done_cnt < n) begin
      pick = $urandom_range(99);
      if (pick < 10 && !gen_open) begin
        // Stray beat with no packet open; the block drops it.
        queue_beat(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)));
        done_cnt++;
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) len = $urandom_range(6);
        else if (pick < 90) len = $urandom_range(24, 7);
        else len = $urandom_range(255, 25);
        k = (len == 0) ? 1 : len;
        if (len > 24) k = $urandom_range(8, 1);
        else if (len > 1 && $urandom_range(99) < 15) k = $urandom_range(len - 1, 1);
        queue_beat(pick_byte(), 1'b1, 8'(len));
        for (int i = 1; i < k; i++) queue_beat(pick_byte(), 1'b0, 8'($urandom_range(255)));
        gen_open = (k < len);
        done_cnt += k;
      end
    end
  endtask

  task automatic wait_sent();
    while (pending_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] hit_7e;
    logic [7:0] hit_7d;
    for (int b = 0; b < 256; b++) begin
      if (pec_step(pec_step(8'd0, 8'd1), 8'(b)) == SOF_BYTE) hit_7e = 8'(b);
      if (pec_step(pec_step(8'd0, 8'd1), 8'(b)) == ESC_BYTE) hit_7d = 8'(b);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 16;
    rx_idle_pct = 82;

    // Zero-length packet, then a stray beat with nothing open.
    queue_beat(8'hFF, 1'b1, 8'd0);
    queue_beat(SOF_BYTE, 1'b0, 8'hFF);
    // Payloads that need escaping.
    queue_beat(SOF_BYTE, 1'b1, 8'd1);
    queue_beat(ESC_BYTE, 1'b1, 8'd2);
    queue_beat(8'h00, 1'b0, 8'h00);
    // Checksums that land on the flag and the escape byte.
    queue_beat(hit_7e, 1'b1, 8'd1);
    queue_beat(hit_7d, 1'b1, 8'd1);
    // Escaped lengths and the largest length, each abandoned by the next packet.
    queue_beat(8'hFF, 1'b1, SOF_BYTE);
    queue_beat(8'h80, 1'b0, 8'h5A);
    queue_beat(ESC_BYTE, 1'b1, ESC_BYTE);
    queue_beat(8'h00, 1'b1, 8'hFF);
    queue_beat(8'h01, 1'b0, 8'h00);
    // A whole short packet, then another stray beat.
    queue_beat(8'h12, 1'b1, 8'd3);
    queue_beat(8'h34, 1'b0, 8'hA5);
    queue_beat(8'hFF, 1'b0, 8'h5A);
    queue_beat(8'h00, 1'b0, 8'h00);

    make_random_items(120);
    wait_sent();

    tx_idle_pct = 82;
    rx_idle_pct = 16;
    make_random_items(120);
    wait_sent();

    // No idling; the long receiver hold-off backs the block up into its input.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_ask = 1'b1;
    make_random_items(124);
    wait_sent();

    while (symbol_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ir_packet_framer_symbol_encoder_unit_tb: done, clean");
    end else begin
      $display("ir_packet_framer_symbol_encoder_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ir_packet_framer_symbol_encoder_unit_tb: done, errors");
    $finish;
  end

endmodule
